// ----- rtl/qjt_pkg.sv -----
`timescale 1ns / 1ps
package qjt_pkg;

	localparam int JOINTS_DEF = 7;

	localparam int JOINT_W = 4;
	localparam int POS_W   = 32;
	localparam int DELTA_W = 33;
	localparam int TICK_W  = 32;
	localparam int FRAC    = 30;
	localparam int TAU_W   = FRAC + 1;
	localparam int POLY_W  = 40;
	localparam int DER_W   = 40;
	localparam int MUL_A_W = DELTA_W;
	localparam int MUL_R_W = MUL_A_W + POLY_W - FRAC;

	localparam logic [TAU_W-1:0] TAU_ONE = TAU_W'(1) << FRAC;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_TICK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_TICK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DURATION = 2'd2;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	// front end to joint sequencer
	typedef struct packed {
		cmd_t                       cmd;
		logic [JOINT_W-1:0]         joint;
		logic signed [POS_W-1:0]    start;
		logic signed [DELTA_W-1:0]  delta;
		logic signed [POLY_W-1:0]   s;
		logic signed [POLY_W-1:0]   sd;
		logic signed [POLY_W-1:0]   sdd;
	} front_t;

	// joint sequencer to evaluation pipeline
	typedef struct packed {
		logic [JOINT_W-1:0]         joint;
		logic                       last;
		logic signed [POS_W-1:0]    start;
		logic signed [DELTA_W-1:0]  delta;
		logic signed [POLY_W-1:0]   s;
		logic signed [POLY_W-1:0]   sd;
		logic signed [POLY_W-1:0]   sdd;
	} issue_t;

endpackage

// ----- rtl/qjt_front.sv -----
`timescale 1ns / 1ps
module qjt_front import qjt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  cmd_t                       cmd,
	input  logic [JOINT_W-1:0]         joint_sel,
	input  logic signed [POS_W-1:0]    start_pos,
	input  logic signed [POS_W-1:0]    final_pos,
	input  logic [TICK_W-1:0]          sample_tick,
	input  logic [TICK_W-1:0]          start_tick,
	input  logic [TICK_W-1:0]          end_tick,
	input  logic [TICK_W-1:0]          inv_duration,
	output logic                       out_valid,
	input  logic                       out_ready,
	output front_t                     out
);

	typedef struct packed {
		cmd_t                       cmd;
		logic [JOINT_W-1:0]         joint;
		logic signed [POS_W-1:0]    start;
		logic signed [DELTA_W-1:0]  delta;
	} load_t;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	load_t ld_in, ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7;

	logic [TICK_W-1:0] t_clamp, elapsed;
	logic [TICK_W-1:0] elapsed_s1;
	logic [2*TICK_W-1:0] prod;
	logic sat;
	logic [TAU_W-1:0] tau_s2, tau_s3, tau_s4, tau_s5, tau_s6;
	logic [TAU_W-1:0] t2_s3, t2_s4, t2_s5, t2_s6;
	logic [TAU_W-1:0] t3_s4, t3_s5, t3_s6;
	logic [TAU_W-1:0] t4_s5, t4_s6;
	logic [TAU_W-1:0] t5_s6;
	logic [2*TAU_W-1:0] sq3, sq4, sq5, sq6;
	logic signed [POLY_W-1:0] e1, e2, e3, e4, e5;
	logic signed [POLY_W-1:0] s_s7, sd_s7, sdd_s7;

	assign en       = !v_s7 || out_ready;
	assign in_ready = en;

	always_comb begin
		ld_in.cmd   = cmd;
		ld_in.joint = joint_sel;
		ld_in.start = start_pos;
		ld_in.delta = $signed({final_pos[POS_W-1], final_pos})
			- $signed({start_pos[POS_W-1], start_pos});
		t_clamp = (sample_tick >= end_tick) ? end_tick : sample_tick;
		elapsed = (t_clamp <= start_tick) ? '0 : t_clamp - start_tick;
	end

	// tau in Q1.30, saturated to one
	assign prod = (2*TICK_W)'(elapsed_s1) * (2*TICK_W)'(inv_duration);
	assign sat  = (prod[2*TICK_W-1:TICK_W] > TICK_W'(1))
		|| (prod[2*TICK_W-1:TICK_W] == TICK_W'(1) && prod[TICK_W-1:2] != '0);

	assign sq3 = (2*TAU_W)'(tau_s2) * (2*TAU_W)'(tau_s2);
	assign sq4 = (2*TAU_W)'(t2_s3) * (2*TAU_W)'(tau_s3);
	assign sq5 = (2*TAU_W)'(t3_s4) * (2*TAU_W)'(tau_s4);
	assign sq6 = (2*TAU_W)'(t4_s5) * (2*TAU_W)'(tau_s5);

	always_comb begin
		e1 = POLY_W'(tau_s6);
		e2 = POLY_W'(t2_s6);
		e3 = POLY_W'(t3_s6);
		e4 = POLY_W'(t4_s6);
		e5 = POLY_W'(t5_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_s1 <= ld_in;
			ld_s2 <= ld_s1;
			ld_s3 <= ld_s2;
			ld_s4 <= ld_s3;
			ld_s5 <= ld_s4;
			ld_s6 <= ld_s5;
			ld_s7 <= ld_s6;

			elapsed_s1 <= elapsed;
			tau_s2     <= sat ? TAU_ONE : prod[TAU_W+1:2];

			t2_s3  <= sq3[FRAC+TAU_W-1:FRAC];
			tau_s3 <= tau_s2;

			t3_s4  <= sq4[FRAC+TAU_W-1:FRAC];
			t2_s4  <= t2_s3;
			tau_s4 <= tau_s3;

			t4_s5  <= sq5[FRAC+TAU_W-1:FRAC];
			t3_s5  <= t3_s4;
			t2_s5  <= t2_s4;
			tau_s5 <= tau_s4;

			t5_s6  <= sq6[FRAC+TAU_W-1:FRAC];
			t4_s6  <= t4_s5;
			t3_s6  <= t3_s5;
			t2_s6  <= t2_s5;
			tau_s6 <= tau_s5;

			s_s7   <= 40'sd6 * e5 - 40'sd15 * e4 + 40'sd10 * e3;
			sd_s7  <= 40'sd30 * e4 - 40'sd60 * e3 + 40'sd30 * e2;
			sdd_s7 <= 40'sd120 * e3 - 40'sd180 * e2 + 40'sd60 * e1;
		end
	end

	assign out_valid = v_s7;

	always_comb begin
		out.cmd   = ld_s7.cmd;
		out.joint = ld_s7.joint;
		out.start = ld_s7.start;
		out.delta = ld_s7.delta;
		out.s     = s_s7;
		out.sd    = sd_s7;
		out.sdd   = sdd_s7;
	end

endmodule

// ----- rtl/qjt_seq.sv -----
`timescale 1ns / 1ps
module qjt_seq import qjt_pkg::*; #(
	parameter int JOINTS = JOINTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  front_t  in,
	output logic    iss_valid,
	input  logic    iss_ready,
	output issue_t  iss
);

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	logic busy_q;
	logic [JW-1:0] cnt_q;
	logic take, is_last, load_hit;
	logic signed [POS_W-1:0]   start_tab_q [JOINTS];
	logic signed [DELTA_W-1:0] delta_tab_q [JOINTS];
	logic signed [POLY_W-1:0]  s_q, sd_q, sdd_q;

	assign in_ready = !busy_q;
	assign take     = in_valid && !busy_q;
	assign is_last  = (cnt_q == JW'(JOINTS - 1));
	// drop loads to joints that do not exist
	assign load_hit = take && (in.cmd == CMD_LOAD)
		&& ({1'b0, in.joint} < (JOINT_W + 1)'(JOINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take && in.cmd == CMD_EVAL) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && iss_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + JW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in.cmd == CMD_EVAL) begin
			s_q   <= in.s;
			sd_q  <= in.sd;
			sdd_q <= in.sdd;
		end
		if (load_hit) begin
			start_tab_q[in.joint[JW-1:0]] <= in.start;
			delta_tab_q[in.joint[JW-1:0]] <= in.delta;
		end
	end

	assign iss_valid = busy_q;

	always_comb begin
		iss.joint = JOINT_W'(cnt_q);
		iss.last  = is_last;
		iss.start = start_tab_q[cnt_q];
		iss.delta = delta_tab_q[cnt_q];
		iss.s     = s_q;
		iss.sd    = sd_q;
		iss.sdd   = sdd_q;
	end

endmodule

// ----- rtl/qjt_mulq30.sv -----
`timescale 1ns / 1ps
module qjt_mulq30 import qjt_pkg::*; #(
	parameter int A_W = MUL_A_W,
	parameter int B_W = POLY_W
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [A_W-1:0]            a,
	input  logic [B_W-1:0]            b,
	input  logic                      neg,
	output logic [A_W+B_W-FRAC-1:0]   r,
	output logic                      neg_out
);

	localparam int SPLIT = 18;
	localparam int PL_W  = A_W + SPLIT;
	localparam int PH_W  = A_W + B_W - SPLIT;
	localparam int P_W   = A_W + B_W;

	logic [PL_W-1:0] pl, pl_s2;
	logic [PH_W-1:0] ph, ph_s2;
	logic [P_W-1:0]  sum;
	logic neg_s2, neg_s3;
	logic [P_W-FRAC-1:0] r_s3;

	// split the magnitude product in two partial products
	assign pl  = PL_W'(a) * PL_W'(b[SPLIT-1:0]);
	assign ph  = PH_W'(a) * PH_W'(b[B_W-1:SPLIT]);
	assign sum = {ph_s2, {SPLIT{1'b0}}} + P_W'(pl_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2  <= pl;
			ph_s2  <= ph;
			neg_s2 <= neg;
			r_s3   <= sum[P_W-1:FRAC];
			neg_s3 <= neg_s2;
		end
	end

	assign r       = r_s3;
	assign neg_out = neg_s3;

endmodule

// ----- rtl/qjt_eval.sv -----
`timescale 1ns / 1ps
module qjt_eval import qjt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     iss_valid,
	output logic                     iss_ready,
	input  issue_t                   iss,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [JOINT_W-1:0]       joint_out,
	output logic signed [POS_W-1:0]  position,
	output logic signed [DER_W-1:0]  velocity,
	output logic signed [DER_W-1:0]  acceleration,
	output logic                     last
);

	localparam int SUM_W = MUL_R_W + 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [JOINT_W-1:0] joint_s1, joint_s2, joint_s3, joint_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [POS_W-1:0] start_s1, start_s2, start_s3;
	logic [MUL_A_W-1:0] a_s1;
	logic nd_s1, ns_s1, nsd_s1, nsdd_s1;
	logic [POLY_W-1:0] bs_s1, bsd_s1, bsdd_s1;
	logic [MUL_R_W-1:0] rs, rsd, rsdd;
	logic ns_s3, nsd_s3, nsdd_s3;
	logic signed [SUM_W-1:0] vs, vsd, vsdd, pos_sum;
	logic ovf;
	logic signed [POS_W-1:0] pos_s4;
	logic signed [DER_W-1:0] vel_s4, acc_s4;

	assign en        = !v_s4 || out_ready;
	assign iss_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// truncate toward zero: multiply magnitudes, sign at the end
	always_ff @(posedge clk) begin
		if (en) begin
			joint_s1 <= iss.joint;
			last_s1  <= iss.last;
			start_s1 <= iss.start;
			nd_s1    <= iss.delta[DELTA_W-1];
			a_s1     <= iss.delta[DELTA_W-1] ? MUL_A_W'(-iss.delta) : MUL_A_W'(iss.delta);
			ns_s1    <= iss.s[POLY_W-1];
			nsd_s1   <= iss.sd[POLY_W-1];
			nsdd_s1  <= iss.sdd[POLY_W-1];
			bs_s1    <= iss.s[POLY_W-1] ? POLY_W'(-iss.s) : POLY_W'(iss.s);
			bsd_s1   <= iss.sd[POLY_W-1] ? POLY_W'(-iss.sd) : POLY_W'(iss.sd);
			bsdd_s1  <= iss.sdd[POLY_W-1] ? POLY_W'(-iss.sdd) : POLY_W'(iss.sdd);

			joint_s2 <= joint_s1;
			last_s2  <= last_s1;
			start_s2 <= start_s1;
			joint_s3 <= joint_s2;
			last_s3  <= last_s2;
			start_s3 <= start_s2;

			joint_s4 <= joint_s3;
			last_s4  <= last_s3;
			pos_s4   <= ovf ? (pos_sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
				: {1'b0, {(POS_W-1){1'b1}}}) : pos_sum[POS_W-1:0];
			vel_s4   <= vsd[DER_W-1:0];
			acc_s4   <= vsdd[DER_W-1:0];
		end
	end

	qjt_mulq30 #(.A_W(MUL_A_W), .B_W(POLY_W)) u_mul_s (
		.clk(clk), .en(en), .a(a_s1), .b(bs_s1), .neg(nd_s1 ^ ns_s1),
		.r(rs), .neg_out(ns_s3)
	);

	qjt_mulq30 #(.A_W(MUL_A_W), .B_W(POLY_W)) u_mul_sd (
		.clk(clk), .en(en), .a(a_s1), .b(bsd_s1), .neg(nd_s1 ^ nsd_s1),
		.r(rsd), .neg_out(nsd_s3)
	);

	qjt_mulq30 #(.A_W(MUL_A_W), .B_W(POLY_W)) u_mul_sdd (
		.clk(clk), .en(en), .a(a_s1), .b(bsdd_s1), .neg(nd_s1 ^ nsdd_s1),
		.r(rsdd), .neg_out(nsdd_s3)
	);

	always_comb begin
		vs      = ns_s3 ? -$signed({2'b00, rs}) : $signed({2'b00, rs});
		vsd     = nsd_s3 ? -$signed({2'b00, rsd}) : $signed({2'b00, rsd});
		vsdd    = nsdd_s3 ? -$signed({2'b00, rsdd}) : $signed({2'b00, rsdd});
		pos_sum = SUM_W'(start_s3) + vs;
		// saturate when the upper bits are not a sign extension
		ovf     = !((&pos_sum[SUM_W-1:POS_W-1]) || !(|pos_sum[SUM_W-1:POS_W-1]));
	end

	assign out_valid    = v_s4;
	assign joint_out    = joint_s4;
	assign position     = pos_s4;
	assign velocity     = vel_s4;
	assign acceleration = acc_s4;
	assign last         = last_s4;

endmodule

// ----- rtl/quintic_joint_trajectory.sv -----
`timescale 1ns / 1ps
// Minimum-jerk quintic trajectory generator for JOINTS joints.
// Input stream s_*: tuser selects the item kind. A load item stores one
// joint's start position and its distance to the final position; an evaluate
// item carries a sample time and yields one result per joint, in joint order,
// on the output stream m_*, with tlast on the last joint. Loads yield nothing.
// Configuration (cfg_*) holds start tick, end tick and the Q0.32 reciprocal
// of the duration; cfg_ready is always high. Write it only while idle.
// A seven-stage front end (clamp, tau, four powers, polynomials) takes an
// item per cycle while its output is not stalled; the joint sequencer then
// reads one table entry per cycle while the evaluation pipeline accepts, so
// an evaluate holds the sequencer until its last joint is issued, while a
// load does not hold it. Each joint runs through a four-stage multiply pipeline.
// Reset clears the configuration and empties all stages; the joint tables are
// undefined until loaded. When m_tready is low the output pipeline holds, the
// sequencer holds, the front end fills and s_tready drops; nothing is lost.
module quintic_joint_trajectory import qjt_pkg::*; #(
	parameter int JOINTS = JOINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// joint_sel[3:0], start_pos[35:4], final_pos[67:36], sample_tick[99:68]
	input  logic [103:0]          s_tdata,
	// command[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// joint_out[3:0], position[35:4], velocity[75:36], acceleration[115:76]
	output logic [119:0]          m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TICK_W-1:0]     cfg_data
);

	logic [TICK_W-1:0] start_tick_q, end_tick_q, inv_duration_q;
	logic front_valid, front_ready;
	front_t front;
	logic iss_valid, iss_ready;
	issue_t iss;
	logic [JOINT_W-1:0] joint_out;
	logic signed [POS_W-1:0] position;
	logic signed [DER_W-1:0] velocity, acceleration;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_tick_q   <= '0;
			end_tick_q     <= '0;
			inv_duration_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_TICK:   start_tick_q   <= cfg_data;
				REG_END_TICK:     end_tick_q     <= cfg_data;
				REG_INV_DURATION: inv_duration_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qjt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.cmd(cmd_t'(s_tuser)),
		.joint_sel(s_tdata[3:0]),
		.start_pos(s_tdata[35:4]),
		.final_pos(s_tdata[67:36]),
		.sample_tick(s_tdata[99:68]),
		.start_tick(start_tick_q),
		.end_tick(end_tick_q),
		.inv_duration(inv_duration_q),
		.out_valid(front_valid),
		.out_ready(front_ready),
		.out(front)
	);

	qjt_seq #(.JOINTS(JOINTS)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(front_valid),
		.in_ready(front_ready),
		.in(front),
		.iss_valid(iss_valid),
		.iss_ready(iss_ready),
		.iss(iss)
	);

	qjt_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.iss_valid(iss_valid),
		.iss_ready(iss_ready),
		.iss(iss),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.joint_out(joint_out),
		.position(position),
		.velocity(velocity),
		.acceleration(acceleration),
		.last(m_tlast)
	);

	assign m_tdata = {4'b0000, acceleration, velocity, position, joint_out};

	// tlast only on the highest joint
	a_last_joint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[3:0] == JOINT_W'(JOINTS - 1))
		else $error("tlast on a joint other than the last");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		iss_valid && iss.last && iss_ready |=> !iss_valid)
		else $error("sequencer kept issuing after the last joint");

	a_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!front_valid |-> s_tready)
		else $error("input stalled with an empty front end");

	a_seq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		iss_valid |-> !front_ready)
		else $error("sequencer took an item while emitting joints");

endmodule
